[hdl/triangle_pixel_coverage_interp_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the triangle coverage block.
// Concurrent checks are clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef TRIANGLE_PIXEL_COVERAGE_INTERP_MACROS_SVH
`define TRIANGLE_PIXEL_COVERAGE_INTERP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define TPCI_ASSERT_HOLDS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define TPCI_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define TPCI_ASSERT_HOLDS(label, expr)
`define TPCI_ASSERT_IMPLIES(label, ante, cons)
`endif

`endif

[hdl/tpci_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Triangle coverage package
// Shared constants, types and arithmetic helpers.
// ---------------------------------------------------------------------------
package tpci_pkg;

    localparam int COORD_WIDTH      = 16;
    localparam int COORD_FRAC_BITS  = 4;
    localparam int WEIGHT_FRAC_BITS = 16;

    localparam int DIFF_W   = COORD_WIDTH + 1;
    localparam int CROSS_W  = 2 * DIFF_W + 1;
    localparam int QUO_W    = 33;
    localparam int DIV_W    = 82;
    localparam int ZTERM_W  = 64 - WEIGHT_FRAC_BITS;
    localparam int Z_W      = ZTERM_W + 2;
    localparam int STAGES   = 2 * QUO_W + 5;
    localparam int IN_W     = 32;
    localparam int OUT_W    = 136;

    typedef enum logic [2:0] {
        REG_A_POS   = 3'd0,
        REG_B_POS   = 3'd1,
        REG_C_POS   = 3'd2,
        REG_A_DEPTH = 3'd3,
        REG_B_DEPTH = 3'd4,
        REG_C_DEPTH = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] dvs;
        logic [QUO_W-1:0] quo;
    } div_state_t;

    typedef struct packed {
        logic covered;
        logic degen;
        logic neg_b;
        logic neg_g;
    } wside_t;

    typedef struct packed {
        logic               covered;
        logic               degen;
        logic signed [31:0] alpha;
        logic signed [31:0] beta;
        logic signed [31:0] gamma;
        logic               zinv;
        logic               negz;
    } dside_t;

    function automatic logic signed [DIFF_W-1:0] sub_coord(
        input logic [COORD_WIDTH-1:0] a,
        input logic [COORD_WIDTH-1:0] b
    );
        return $signed({a[COORD_WIDTH-1], a}) - $signed({b[COORD_WIDTH-1], b});
    endfunction

    function automatic logic signed [CROSS_W-1:0] cross2(
        input logic signed [DIFF_W-1:0] ax,
        input logic signed [DIFF_W-1:0] ay,
        input logic signed [DIFF_W-1:0] bx,
        input logic signed [DIFF_W-1:0] by
    );
        logic signed [CROSS_W-1:0] t0;
        logic signed [CROSS_W-1:0] t1;
        t0 = CROSS_W'(ax) * CROSS_W'(by);
        t1 = CROSS_W'(ay) * CROSS_W'(bx);
        return t0 - t1;
    endfunction

    function automatic logic [CROSS_W-1:0] mag_cross(input logic signed [CROSS_W-1:0] v);
        return v[CROSS_W-1] ? CROSS_W'(-v) : CROSS_W'(v);
    endfunction

    function automatic logic signed [31:0] sat_quo(
        input logic [QUO_W-1:0] q,
        input logic             neg
    );
        logic [QUO_W-1:0]   m;
        logic signed [31:0] r;
        m = q[QUO_W-1] ? {1'b1, 32'd0} : q;
        if (neg)
        begin
            r = (m >= 33'h0_8000_0000) ? 32'sh8000_0000 : -$signed(m[31:0]);
        end
        else
        begin
            r = (m > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(m[31:0]);
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh0_7FFF_FFFF)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -34'sh0_8000_0000)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[hdl/tpci_div_cell.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Division cell
// One restoring division step per cell: compare, subtract and shift.
// ---------------------------------------------------------------------------
module tpci_div_cell (
    input  logic                   clk,
    input  logic                   en,
    input  tpci_pkg::div_state_t   d_in,
    output tpci_pkg::div_state_t   d_out
);

    tpci_pkg::div_state_t state_reg;
    tpci_pkg::div_state_t state_next;

    always_comb
    begin
        state_next.dvs = d_in.dvs >> 1;
        if (d_in.rem >= d_in.dvs)
        begin
            state_next.rem = d_in.rem - d_in.dvs;
            state_next.quo = {d_in.quo[tpci_pkg::QUO_W-2:0], 1'b1};
        end
        else
        begin
            state_next.rem = d_in.rem;
            state_next.quo = {d_in.quo[tpci_pkg::QUO_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            state_reg <= state_next;
        end
    end

    assign d_out = state_reg;

endmodule

[hdl/triangle_pixel_coverage_interp.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Triangle pixel coverage and barycentric interpolation
// Edge tests, barycentric weights and interpolated depth for sample points.
// ---------------------------------------------------------------------------
// The block takes one sample point per clock and returns one result per
// clock. Its pipeline is set mostly by two runs of 33 division cells: in the
// first, two parallel chains form the two weight quotients; the second forms
// minus one over the interpolated depth term.
// The whole pipeline stalls only when the output item is held.
`include "triangle_pixel_coverage_interp_macros.svh"

module triangle_pixel_coverage_interp (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // point_x [15:0], point_y [31:16]
    input  logic [31:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // inside_res [0], degenerate [1], weight_alpha [33:2], weight_beta [65:34],
    // weight_gamma [97:66], depth_value [129:98], depth_invalid [130], zero [135:131]
    output logic [135:0] m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int QW = tpci_pkg::QUO_W;
    localparam int DW = tpci_pkg::DIV_W;
    localparam int CW = tpci_pkg::COORD_WIDTH;
    localparam int WF = tpci_pkg::WEIGHT_FRAC_BITS;

    logic [31:0] a_pos_reg, b_pos_reg, c_pos_reg;
    logic [31:0] a_depth_reg, b_depth_reg, c_depth_reg;

    logic adv;
    logic [tpci_pkg::STAGES-1:0] vld_reg;

    assign cfg_ready     = 1'b1;
    assign adv           = !vld_reg[tpci_pkg::STAGES-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[tpci_pkg::STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_pos_reg   <= '0;
            b_pos_reg   <= '0;
            c_pos_reg   <= '0;
            a_depth_reg <= '0;
            b_depth_reg <= '0;
            c_depth_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tpci_pkg::REG_A_POS:   a_pos_reg   <= cfg_data;
                tpci_pkg::REG_B_POS:   b_pos_reg   <= cfg_data;
                tpci_pkg::REG_C_POS:   c_pos_reg   <= cfg_data;
                tpci_pkg::REG_A_DEPTH: a_depth_reg <= cfg_data;
                tpci_pkg::REG_B_DEPTH: b_depth_reg <= cfg_data;
                tpci_pkg::REG_C_DEPTH: c_depth_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[tpci_pkg::STAGES-2:0], s_axis_tvalid};
        end
    end

    // Front stage: edge functions and weight numerators.
    logic [CW-1:0] ax, ay, bx, by, cx, cy, px, py;
    logic signed [tpci_pkg::DIFF_W-1:0] v0x, v0y, v1x, v1y, v2x, v2y;
    logic signed [tpci_pkg::CROSS_W-1:0] e_ab, e_bc, e_ca, den, nb, ng;
    tpci_pkg::div_state_t wb0_next, wg0_next;
    tpci_pkg::wside_t     ws0_next;

    always_comb
    begin
        ax = a_pos_reg[15:0];
        ay = a_pos_reg[31:16];
        bx = b_pos_reg[15:0];
        by = b_pos_reg[31:16];
        cx = c_pos_reg[15:0];
        cy = c_pos_reg[31:16];
        px = s_axis_tdata[15:0];
        py = s_axis_tdata[31:16];
        v0x = tpci_pkg::sub_coord(bx, ax);
        v0y = tpci_pkg::sub_coord(by, ay);
        v1x = tpci_pkg::sub_coord(cx, ax);
        v1y = tpci_pkg::sub_coord(cy, ay);
        v2x = tpci_pkg::sub_coord(px, ax);
        v2y = tpci_pkg::sub_coord(py, ay);
        e_ab = tpci_pkg::cross2(v2x, v2y, v0x, v0y);
        e_bc = tpci_pkg::cross2(tpci_pkg::sub_coord(px, bx), tpci_pkg::sub_coord(py, by),
                                tpci_pkg::sub_coord(cx, bx), tpci_pkg::sub_coord(cy, by));
        e_ca = tpci_pkg::cross2(tpci_pkg::sub_coord(px, cx), tpci_pkg::sub_coord(py, cy),
                                tpci_pkg::sub_coord(ax, cx), tpci_pkg::sub_coord(ay, cy));
        den  = tpci_pkg::cross2(v0x, v0y, v1x, v1y);
        nb   = tpci_pkg::cross2(v2x, v2y, v1x, v1y);
        ng   = tpci_pkg::cross2(v0x, v0y, v2x, v2y);

        ws0_next.covered = !e_ab[tpci_pkg::CROSS_W-1] && !e_bc[tpci_pkg::CROSS_W-1]
                        && !e_ca[tpci_pkg::CROSS_W-1];
        ws0_next.degen   = (den == '0);
        ws0_next.neg_b   = nb[tpci_pkg::CROSS_W-1] != den[tpci_pkg::CROSS_W-1];
        ws0_next.neg_g   = ng[tpci_pkg::CROSS_W-1] != den[tpci_pkg::CROSS_W-1];

        wb0_next.rem = DW'(tpci_pkg::mag_cross(nb)) << WF;
        wb0_next.dvs = DW'(tpci_pkg::mag_cross(den)) << (QW - 1);
        wb0_next.quo = '0;
        wg0_next.rem = DW'(tpci_pkg::mag_cross(ng)) << WF;
        wg0_next.dvs = wb0_next.dvs;
        wg0_next.quo = '0;
    end

    tpci_pkg::div_state_t wb [0:QW];
    tpci_pkg::div_state_t wg [0:QW];
    tpci_pkg::wside_t     ws_reg [0:QW];
    tpci_pkg::div_state_t wb0_reg, wg0_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wb0_reg   <= wb0_next;
            wg0_reg   <= wg0_next;
            ws_reg[0] <= ws0_next;
            for (int k = 1; k <= QW; k++)
            begin
                ws_reg[k] <= ws_reg[k-1];
            end
        end
    end

    assign wb[0] = wb0_reg;
    assign wg[0] = wg0_reg;

    for (genvar k = 0; k < QW; k++)
    begin : g_wchain
        tpci_div_cell u_cell_b (.clk(clk), .en(adv), .d_in(wb[k]), .d_out(wb[k+1]));
        tpci_div_cell u_cell_g (.clk(clk), .en(adv), .d_in(wg[k]), .d_out(wg[k+1]));
    end

    // Weight stage.
    logic signed [31:0] beta_next, gamma_next;
    logic signed [33:0] alpha_sum;
    logic signed [31:0] w_alpha_reg, w_beta_reg, w_gamma_reg;
    logic               w_inside_reg, w_degen_reg;

    always_comb
    begin
        if (ws_reg[QW].degen)
        begin
            beta_next  = '0;
            gamma_next = '0;
        end
        else
        begin
            beta_next  = tpci_pkg::sat_quo(wb[QW].quo, ws_reg[QW].neg_b);
            gamma_next = tpci_pkg::sat_quo(wg[QW].quo, ws_reg[QW].neg_g);
        end
        alpha_sum = (34'sd1 <<< WF) - 34'(beta_next) - 34'(gamma_next);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_beta_reg   <= beta_next;
            w_gamma_reg  <= gamma_next;
            w_alpha_reg  <= ws_reg[QW].degen ? 32'sd0 : tpci_pkg::sat34(alpha_sum);
            w_inside_reg <= ws_reg[QW].covered;
            w_degen_reg  <= ws_reg[QW].degen;
        end
    end

    // Product stage.
    logic signed [63:0] m_pa_reg, m_pb_reg, m_pc_reg;
    logic signed [31:0] m_alpha_reg, m_beta_reg, m_gamma_reg;
    logic               m_inside_reg, m_degen_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_pa_reg     <= 64'(w_alpha_reg) * 64'($signed(a_depth_reg));
            m_pb_reg     <= 64'(w_beta_reg) * 64'($signed(b_depth_reg));
            m_pc_reg     <= 64'(w_gamma_reg) * 64'($signed(c_depth_reg));
            m_alpha_reg  <= w_alpha_reg;
            m_beta_reg   <= w_beta_reg;
            m_gamma_reg  <= w_gamma_reg;
            m_inside_reg <= w_inside_reg;
            m_degen_reg  <= w_degen_reg;
        end
    end

    // Depth term sum and depth division setup.
    logic signed [tpci_pkg::Z_W-1:0] z_sum;
    logic [tpci_pkg::Z_W-1:0]        z_mag;
    tpci_pkg::div_state_t            d0_next;
    tpci_pkg::dside_t                ds0_next;

    always_comb
    begin
        z_sum = tpci_pkg::Z_W'($signed(m_pa_reg[63:WF]))
              + tpci_pkg::Z_W'($signed(m_pb_reg[63:WF]))
              + tpci_pkg::Z_W'($signed(m_pc_reg[63:WF]));
        z_mag = z_sum[tpci_pkg::Z_W-1] ? tpci_pkg::Z_W'(-z_sum) : tpci_pkg::Z_W'(z_sum);
        d0_next.rem = DW'(1) << 32;
        d0_next.dvs = DW'(z_mag) << (QW - 1);
        d0_next.quo = '0;
        ds0_next.covered = m_inside_reg;
        ds0_next.degen   = m_degen_reg;
        ds0_next.alpha   = m_alpha_reg;
        ds0_next.beta    = m_beta_reg;
        ds0_next.gamma   = m_gamma_reg;
        ds0_next.zinv    = (z_sum == '0);
        ds0_next.negz    = !z_sum[tpci_pkg::Z_W-1];
    end

    tpci_pkg::div_state_t dd [0:QW];
    tpci_pkg::dside_t     ds_reg [0:QW];
    tpci_pkg::div_state_t d0_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d0_reg    <= d0_next;
            ds_reg[0] <= ds0_next;
            for (int k = 1; k <= QW; k++)
            begin
                ds_reg[k] <= ds_reg[k-1];
            end
        end
    end

    assign dd[0] = d0_reg;

    for (genvar k = 0; k < QW; k++)
    begin : g_dchain
        tpci_div_cell u_cell_d (.clk(clk), .en(adv), .d_in(dd[k]), .d_out(dd[k+1]));
    end

    // Output register.
    logic               out_inside_reg, out_degen_reg, out_zinv_reg;
    logic signed [31:0] out_alpha_reg, out_beta_reg, out_gamma_reg, out_depth_reg;
    logic               out_weights_zero;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_inside_reg <= ds_reg[QW].covered;
            out_degen_reg  <= ds_reg[QW].degen;
            out_alpha_reg  <= ds_reg[QW].alpha;
            out_beta_reg   <= ds_reg[QW].beta;
            out_gamma_reg  <= ds_reg[QW].gamma;
            out_zinv_reg   <= ds_reg[QW].zinv;
            out_depth_reg  <= ds_reg[QW].zinv ? 32'sd0
                            : tpci_pkg::sat_quo(dd[QW].quo, ds_reg[QW].negz);
        end
    end

    assign m_axis_tdata = {5'd0, out_zinv_reg, out_depth_reg, out_gamma_reg, out_beta_reg,
                           out_alpha_reg, out_degen_reg, out_inside_reg};

    assign out_weights_zero = (out_alpha_reg == 0) && (out_beta_reg == 0)
                           && (out_gamma_reg == 0);

    `TPCI_ASSERT_IMPLIES(a_degen_zero, m_axis_tvalid && out_degen_reg, out_weights_zero && out_zinv_reg)
    `TPCI_ASSERT_IMPLIES(a_zinv_depth, m_axis_tvalid && out_zinv_reg, out_depth_reg == 0)
    `TPCI_ASSERT_HOLDS(a_ready_rule, s_axis_tready == (!m_axis_tvalid || m_axis_tready))

endmodule
